[sv/trd_pkg.sv]
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

    // Configuration register indexes
    localparam logic [0:0] REG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [0:0] REG_PIXEL_TOTAL     = 1'd1;

    localparam logic [2:0]  BPP_RESET        = 3'd4;
    localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd1;

    localparam logic [7:0] COUNT_MASK = 8'h7F;
    localparam logic [7:0] FULL_BYTE  = 8'hFF;

    typedef enum logic [0:0] {
        PH_HEADER,
        PH_PIXEL
    } phase_t;

    // One decoded result as it travels to the output register.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_res;
        logic       image_done;
        logic       status;
    } result_t;

    // Effective pixel size minus one: sizes below 2 act as 2, above 4 as 4.
    function automatic logic [1:0] last_position(input logic [2:0] bpp);
        logic [1:0] pos;
        begin
            case (bpp)
                3'd3:    pos = 2'd2;
                3'd0, 3'd1, 3'd2: pos = 2'd1;
                default: pos = 2'd3;
            endcase
            return pos;
        end
    endfunction

endpackage

`default_nettype wire

[sv/trd_parse.sv]
// ----------------------------------------------------------------------------
// trd_parse
// Packet header parsing, pixel assembly, colour conversion and pixel counting.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_parse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              accept,
    input  wire logic [7:0]        stream_byte,
    input  wire logic              final_byte,
    output logic                   res_valid,
    output trd_pkg::result_t       res
);
    import trd_pkg::*;

    logic [2:0]  bpp_reg;
    logic [31:0] total_reg;

    phase_t      phase_reg, phase_next;
    logic        run_reg, run_next;
    logic [6:0]  raw_left_reg, raw_left_next;
    logic [7:0]  run_len_reg, run_len_next;
    logic [1:0]  pos_reg, pos_next;
    logic [23:0] partial_reg, partial_next;
    logic [31:0] decoded_reg, decoded_next;

    logic [1:0]  last_pos;
    logic [31:0] total;
    logic [31:0] remaining;
    logic [7:0]  count_raw;
    logic [7:0]  count;
    logic        done;
    logic [15:0] v16;
    logic [7:0]  r, g, b, a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= BPP_RESET;
            total_reg <= PIXEL_TOTAL_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BYTES_PER_PIXEL: bpp_reg   <= cfg_data[2:0];
                REG_PIXEL_TOTAL:     total_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        last_pos  = last_position(bpp_reg);
        total     = (total_reg == 32'd0) ? 32'd1 : total_reg;
        remaining = (total > decoded_reg) ? (total - decoded_reg) : 32'd0;
        count_raw = run_reg ? run_len_reg : 8'd1;
        count     = ({24'd0, count_raw} > remaining) ? remaining[7:0] : count_raw;
        // The image completes exactly when the unclamped count covers what is left.
        done      = ({24'd0, count_raw} >= remaining);

        v16 = {stream_byte, partial_reg[7:0]};
        case (last_pos)
            2'd1:
            begin
                r = {v16[14:10], 3'd0};
                g = {v16[9:5], 3'd0};
                b = {v16[4:0], 3'd0};
                a = v16[15] ? FULL_BYTE : 8'd0;
            end
            2'd2:
            begin
                r = stream_byte;
                g = partial_reg[15:8];
                b = partial_reg[7:0];
                a = FULL_BYTE;
            end
            default:
            begin
                r = partial_reg[23:16];
                g = partial_reg[15:8];
                b = partial_reg[7:0];
                a = stream_byte;
            end
        endcase
        if (count == 8'd0)
        begin
            r = 8'd0;
            g = 8'd0;
            b = 8'd0;
            a = 8'd0;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        run_next      = run_reg;
        raw_left_next = raw_left_reg;
        run_len_next  = run_len_reg;
        pos_next      = pos_reg;
        partial_next  = partial_reg;
        decoded_next  = decoded_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.status    = 1'b1;

        if (phase_reg == PH_HEADER)
        begin
            run_next      = stream_byte[7];
            run_len_next  = (stream_byte & COUNT_MASK) + 8'd1;
            raw_left_next = stream_byte[7] ? 7'd0 : stream_byte[6:0];
            pos_next      = 2'd0;
            partial_next  = 24'd0;
            phase_next    = PH_PIXEL;
            res_valid     = final_byte;
        end
        else if (pos_reg < last_pos)
        begin
            case (pos_reg)
                2'd0:    partial_next[7:0]   = partial_reg[7:0] | stream_byte;
                2'd1:    partial_next[15:8]  = partial_reg[15:8] | stream_byte;
                2'd2:    partial_next[23:16] = partial_reg[23:16] | stream_byte;
                default: ;
            endcase
            pos_next  = pos_reg + 2'd1;
            res_valid = final_byte;
        end
        else
        begin
            decoded_next   = decoded_reg + {24'd0, count};
            pos_next       = 2'd0;
            partial_next   = 24'd0;
            res_valid      = 1'b1;
            res.red        = r;
            res.green      = g;
            res.blue       = b;
            res.alpha      = a;
            res.repeat_res = count;
            res.image_done = done;
            res.status     = final_byte && !done;
            if (run_reg || raw_left_reg == 7'd0)
            begin
                phase_next = PH_HEADER;
            end
            else
            begin
                raw_left_next = raw_left_reg - 7'd1;
            end
        end

        // Completion or an early end of stream starts a fresh image.
        if (final_byte || (phase_reg == PH_PIXEL && pos_reg >= last_pos && done))
        begin
            phase_next    = PH_HEADER;
            run_next      = 1'b0;
            raw_left_next = 7'd0;
            run_len_next  = 8'd0;
            pos_next      = 2'd0;
            partial_next  = 24'd0;
            decoded_next  = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            run_reg      <= 1'b0;
            raw_left_reg <= 7'd0;
            run_len_reg  <= 8'd0;
            pos_reg      <= 2'd0;
            partial_reg  <= 24'd0;
            decoded_reg  <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            run_reg      <= run_next;
            raw_left_reg <= raw_left_next;
            run_len_reg  <= run_len_next;
            pos_reg      <= pos_next;
            partial_reg  <= partial_next;
            decoded_reg  <= decoded_next;
        end
    end

endmodule

`default_nettype wire

[sv/trd_outreg.sv]
// ----------------------------------------------------------------------------
// trd_outreg
// Result register holding one decoded transaction until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_outreg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire trd_pkg::result_t  res,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic                   busy,
    output trd_pkg::result_t       res_out
);
    import trd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // A held result blocks new input only while the consumer stalls it.
    assign busy = valid_reg && out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

`default_nettype wire

[sv/tga_rle_pixel_decoder_top.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Decodes a run-length compressed TGA pixel stream into RGBA8 pixels with
// repeat counts.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// config    in         cfg_wr_en             cfg_index, cfg_data
// input     in         in_valid / in_stall   stream_byte, final_byte
// output    out        out_valid / out_stall red, green, blue, alpha,
//                                            repeat_res, image_done, status
//
// Each byte is parsed at the edge that accepts it, and any
// result appears in the output register in the following cycle.
// One byte can be accepted in every cycle; the rate is set by the single
// output register, which stalls input only while a held result is stalled.
// Reset restores bytes_per_pixel 4, pixel_total 1 and the header phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  stream_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic [7:0]       repeat_res,
    output logic             image_done,
    output logic             status
);
    import trd_pkg::*;

    logic    accept;
    logic    res_valid;
    logic    busy;
    result_t res;
    result_t res_out;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    trd_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .stream_byte (stream_byte),
        .final_byte  (final_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    trd_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .busy      (busy),
        .res_out   (res_out)
    );

    assign red        = res_out.red;
    assign green      = res_out.green;
    assign blue       = res_out.blue;
    assign alpha      = res_out.alpha;
    assign repeat_res = res_out.repeat_res;
    assign image_done = res_out.image_done;
    assign status     = res_out.status;

endmodule

`default_nettype wire
